[rtl/ffa_pkg.sv]
// ffa_pkg: shared types, codes and widths for the forest fire automaton step block
// used by ffa_ctrl, ffa_datapath and forest_fire_automaton_step; no dependencies
package ffa_pkg;

  // default grid bounds
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // fixed field widths
  localparam int CELL_W    = 3;
  localparam int IN_ROW_W  = 6;
  localparam int IN_COL_W  = 6;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int WIND_W    = 4;

  // stream widths
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;

  typedef logic [CELL_W-1:0] cell_t;

  // cell codes
  localparam cell_t CELL_EMPTY   = 3'd0;
  localparam cell_t CELL_TREE    = 3'd1;
  localparam cell_t CELL_BURNING = 3'd2;
  localparam cell_t CELL_BURNT   = 3'd3;
  localparam cell_t CELL_WATER   = 3'd4;

  // wind flag bit positions
  localparam int DIR_N = 0;
  localparam int DIR_S = 1;
  localparam int DIR_W = 2;
  localparam int DIR_E = 3;

  localparam logic [WIND_W-1:0] WIND_ALL = 4'hF;
  localparam logic [WIND_W-1:0] WIND_RST = 4'h0;
  localparam logic [CFG_W-1:0]  ROWS_RST = 7'd64;
  localparam logic [CFG_W-1:0]  COLS_RST = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_WIND = 2'd2
  } cfg_e;

  // what one scan slot does
  typedef enum logic [1:0] {
    SCAN_CLEAR,
    SCAN_MARK,
    SCAN_COMMIT
  } scan_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_MARK_END,
    ST_COMMIT,
    ST_COMMIT_END,
    ST_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic  accept;
    logic  restart;
    logic  step;
    scan_e scan;
    logic  resp;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_slot;
    logic dims_zero;
    logic gen_req;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/forest_fire_automaton_step.sv]
// forest_fire_automaton_step: top level of the forest fire grid engine
// depends on ffa_pkg, ffa_ctrl and ffa_datapath
//
// Usage: each word on the slave stream is a command in tuser (write cell, read
// cell, advance one generation) with row, column and cell value in tdata. Every
// accepted word gives exactly one word on the master stream: read value, fire
// flag and out-of-range flag.
// Flow: a read, a write or an unused command goes from accept straight to the
// response state, and the next word is taken once its result is in the output
// register. A generation runs a mark pass and a commit pass over the grid memory
// for R rows and C columns in use, one column slot per cycle plus one flush slot
// per row, before its result is given. A grid with no rows or no columns answers
// as fast as a read.
// One word is worked on at a time.
// Reset: the grid memory is swept to empty over all MAX_ROWS x MAX_COLS cells, with
// s_axis_tready low; configuration writes are taken throughout.
// Stall: a result waits in the output register while m_axis_tready is low, the
// next word is still accepted and its result waits until the register frees up.
// The user must write configuration only while the block is idle; the block itself does not enforce it.
module forest_fire_automaton_step #(
  parameter int MAX_ROWS = ffa_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ffa_pkg::DEF_MAX_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [ffa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffa_pkg::CFG_W-1:0]     cfg_data_i,
  // command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ffa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // row[5:0], col[11:6], cell_value[14:12]
  input  logic [ffa_pkg::S_TUSER_W-1:0] s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ffa_pkg::M_TDATA_W-1:0] m_axis_tdata   // read_value[2:0], fire_remains[3],
                                                       // out_of_range[4]
);
  import ffa_pkg::*;

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  // sequencer
  ffa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // grid storage and update logic
  ffa_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

[rtl/ffa_ctrl.sv]
// ffa_ctrl: sequencer for access words, clearing pass and the two generation passes
// depends on ffa_pkg
module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  ffa_pkg::dp_sts_t  sts_i,
  output ffa_pkg::ctl_cmd_t ctl_o
);
  import ffa_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    ctl_o         = '0;
    ctl_o.scan    = SCAN_MARK;
    s_tready_o    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.scan = SCAN_CLEAR;
        ctl_o.step = 1'b1;
        if (sts_i.last_slot) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          ctl_o.accept  = 1'b1;
          ctl_o.restart = 1'b1;
          if (sts_i.gen_req && !sts_i.dims_zero) state_d = ST_MARK;
          else state_d = ST_RESP;
        end
      end
      ST_MARK: begin
        ctl_o.scan = SCAN_MARK;
        ctl_o.step = 1'b1;
        if (sts_i.last_slot) state_d = ST_MARK_END;
      end
      // last mark lands here, counter rewinds for the commit pass
      ST_MARK_END: begin
        ctl_o.restart = 1'b1;
        state_d       = ST_COMMIT;
      end
      ST_COMMIT: begin
        ctl_o.scan = SCAN_COMMIT;
        ctl_o.step = 1'b1;
        if (sts_i.last_slot) state_d = ST_COMMIT_END;
      end
      ST_COMMIT_END: begin
        ctl_o.scan = SCAN_COMMIT;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.resp = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ffa_datapath.sv]
// ffa_datapath: config registers, grid and mark memories, scan counter, window and result
// depends on ffa_pkg; driven by ffa_ctrl
module ffa_datapath #(
  parameter int MAX_ROWS = ffa_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = ffa_pkg::DEF_MAX_COLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ffa_pkg::ctl_cmd_t               ctl_i,
  output ffa_pkg::dp_sts_t                sts_o,
  input  logic                            cfg_we_i,
  input  logic [ffa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ffa_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [ffa_pkg::S_TDATA_W-1:0]   s_tdata_i,
  input  logic [ffa_pkg::S_TUSER_W-1:0]   s_tuser_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [ffa_pkg::M_TDATA_W-1:0]   m_tdata_o
);
  import ffa_pkg::*;

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int CIDX_W = $clog2(MAX_COLS);
  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int CC_W   = $clog2(MAX_COLS + 1);
  localparam int RCMP_W = (RC_W > CFG_W) ? RC_W : CFG_W;
  localparam int CCMP_W = (CC_W > CFG_W) ? CC_W : CFG_W;
  localparam int HR_W   = (RC_W > IN_ROW_W) ? RC_W : IN_ROW_W;
  localparam int HC_W   = (CC_W > IN_COL_W) ? CC_W : IN_COL_W;

  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [WIND_W-1:0] wind_q, dirs;
  logic [RC_W-1:0]   eff_rows, lim_r, row_next;
  logic [CC_W-1:0]   eff_cols, lim_c;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
      wind_q <= WIND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        CFG_WIND: wind_q <= cfg_data_i[WIND_W-1:0];
        default: ;
      endcase
    end
  end

  // oversized dimensions clamp to the grid bounds
  assign eff_rows = (RCMP_W'(rows_q) > RCMP_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : RC_W'(rows_q);
  assign eff_cols = (CCMP_W'(cols_q) > CCMP_W'(MAX_COLS)) ? CC_W'(MAX_COLS) : CC_W'(cols_q);
  assign dirs     = (wind_q == '0) ? WIND_ALL : wind_q;

  // input word decode
  logic [IN_ROW_W-1:0] in_row;
  logic [IN_COL_W-1:0] in_col;
  cell_t               in_val;
  logic                is_wr, is_rd, host_ok, host_wr, host_rd;
  logic [ADDR_W-1:0]   host_addr;

  assign in_row    = s_tdata_i[IN_ROW_W-1:0];
  assign in_col    = s_tdata_i[IN_ROW_W +: IN_COL_W];
  assign in_val    = s_tdata_i[IN_ROW_W+IN_COL_W +: CELL_W];
  assign is_wr     = (s_tuser_i == CMD_WRITE);
  assign is_rd     = (s_tuser_i == CMD_READ);
  assign host_ok   = (HR_W'(in_row) < HR_W'(eff_rows)) && (HC_W'(in_col) < HC_W'(eff_cols));
  assign host_addr = ADDR_W'(in_row * MAX_COLS + in_col);
  assign host_wr   = ctl_i.accept && is_wr && host_ok && (in_val <= CELL_WATER);
  assign host_rd   = ctl_i.accept && is_rd && host_ok;

  // scan counter: row, column with one flush slot per row, row base address
  logic [RIDX_W-1:0] r_q;
  logic [CC_W-1:0]   c_q;
  logic [ADDR_W-1:0] base_q, scan_addr;
  logic [CIDX_W-1:0] scan_col;
  logic              flush, real_slot, north_ok, south_ok;
  logic              mark_step, commit_step, clear_step;

  assign lim_r       = (ctl_i.scan == SCAN_CLEAR) ? RC_W'(MAX_ROWS) : eff_rows;
  assign lim_c       = (ctl_i.scan == SCAN_CLEAR) ? CC_W'(MAX_COLS) : eff_cols;
  assign row_next    = RC_W'(r_q) + RC_W'(1);
  assign flush       = (c_q == lim_c);
  assign real_slot   = !flush;
  assign north_ok    = (r_q != '0);
  assign south_ok    = (row_next < lim_r);
  assign scan_addr   = base_q + ADDR_W'(c_q);
  assign scan_col    = c_q[CIDX_W-1:0];
  assign mark_step   = ctl_i.step && (ctl_i.scan == SCAN_MARK);
  assign commit_step = ctl_i.step && (ctl_i.scan == SCAN_COMMIT);
  assign clear_step  = ctl_i.step && (ctl_i.scan == SCAN_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      c_q    <= '0;
      base_q <= '0;
    end else if (ctl_i.restart) begin
      r_q    <= '0;
      c_q    <= '0;
      base_q <= '0;
    end else if (ctl_i.step) begin
      if (flush) begin
        c_q    <= '0;
        r_q    <= r_q + RIDX_W'(1);
        base_q <= base_q + ADDR_W'(MAX_COLS);
      end else begin
        c_q <= c_q + CC_W'(1);
      end
    end
  end

  // second stage of a scan slot
  logic              s1_mark_q, s1_commit_q;
  logic              s1_real_q, s1_first_q, s1_n_ok_q, s1_s_ok_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [CIDX_W-1:0] s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_mark_q   <= 1'b0;
      s1_commit_q <= 1'b0;
    end else begin
      s1_mark_q   <= mark_step;
      s1_commit_q <= commit_step;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_real_q  <= real_slot;
    s1_first_q <= (c_q == '0);
    s1_n_ok_q  <= north_ok;
    s1_s_ok_q  <= south_ok;
    s1_addr_q  <= scan_addr;
    s1_col_q   <= scan_col;
  end

  // grid memory: one write port, two registered read ports
  cell_t             grid_mem [CELLS];
  cell_t             qa_q, qb_q, wdata, commit_v;
  logic              we, ra_en, rb_en;
  logic [ADDR_W-1:0] waddr, ra_addr;

  always_comb begin
    we    = 1'b0;
    waddr = scan_addr;
    wdata = CELL_EMPTY;
    if (host_wr) begin
      we    = 1'b1;
      waddr = host_addr;
      wdata = in_val;
    end else if (clear_step && real_slot) begin
      we = 1'b1;
    end else if (s1_commit_q && s1_real_q) begin
      we    = 1'b1;
      waddr = s1_addr_q;
      wdata = commit_v;
    end
  end

  assign ra_addr = ctl_i.accept ? host_addr : scan_addr;
  assign ra_en   = host_rd || ((mark_step || commit_step) && real_slot);
  assign rb_en   = mark_step && real_slot && south_ok;

  always_ff @(posedge clk_i) begin
    if (we) grid_mem[waddr] <= wdata;
    if (ra_en) qa_q <= grid_mem[ra_addr];
    if (rb_en) qb_q <= grid_mem[scan_addr + ADDR_W'(MAX_COLS)];
  end

  // burning bits of the previous row
  logic line_mem [MAX_COLS];
  logic line_q;
  logic cur_b, cur_s, cur_n;

  assign cur_b = s1_real_q && (qa_q == CELL_BURNING);
  assign cur_s = s1_real_q && s1_s_ok_q && (qb_q == CELL_BURNING);
  assign cur_n = s1_real_q && s1_n_ok_q && line_q;

  always_ff @(posedge clk_i) begin
    if (mark_step && real_slot) line_q <= line_mem[scan_col];
    if (s1_mark_q && s1_real_q) line_mem[s1_col_q] <= cur_b;
  end

  // window one column behind the stream
  cell_t pv_q;
  logic  pn_q, ps_q, pb_q, ppb_q, hit, mk_we;

  always_ff @(posedge clk_i) begin
    if (s1_mark_q) begin
      pv_q  <= qa_q;
      pn_q  <= cur_n;
      ps_q  <= cur_s;
      pb_q  <= cur_b;
      ppb_q <= s1_first_q ? 1'b0 : pb_q;
    end
  end

  assign hit = (pv_q == CELL_TREE) &&
               ((dirs[DIR_N] && pn_q) || (dirs[DIR_S] && ps_q) ||
                (dirs[DIR_W] && ppb_q) || (dirs[DIR_E] && cur_b));
  assign mk_we = s1_mark_q && !s1_first_q;

  // ignite marks, written in the mark pass and read in the commit pass
  logic mark_mem [CELLS];
  logic mk_q;

  always_ff @(posedge clk_i) begin
    if (mk_we) mark_mem[s1_addr_q - ADDR_W'(1)] <= hit;
    if (commit_step && real_slot) mk_q <= mark_mem[scan_addr];
  end

  // commit update
  always_comb begin
    if (mk_q) commit_v = CELL_BURNING;
    else if (qa_q == CELL_BURNING) commit_v = CELL_BURNT;
    else commit_v = qa_q;
  end

  // fire flag and pending result
  logic fire_q, pend_rd_q, pend_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire_q     <= 1'b0;
      pend_rd_q  <= 1'b0;
      pend_oor_q <= 1'b0;
    end else if (ctl_i.accept) begin
      fire_q     <= 1'b0;
      pend_rd_q  <= is_rd && host_ok;
      pend_oor_q <= (is_wr || is_rd) && !host_ok;
    end else if (s1_commit_q && s1_real_q && (commit_v == CELL_BURNING)) begin
      fire_q <= 1'b1;
    end
  end

  // output register
  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  cell_t                rd_val;

  assign rd_val = pend_rd_q ? qa_q : CELL_EMPTY;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl_i.resp) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.resp) m_data_q <= M_TDATA_W'({pend_oor_q, fire_q, rd_val});
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  // status
  assign sts_o.last_slot = flush && (row_next == lim_r);
  assign sts_o.dims_zero = (eff_rows == '0) || (eff_cols == '0);
  assign sts_o.gen_req   = (s_tuser_i == CMD_STEP);
  assign sts_o.out_free  = !m_valid_q || m_tready_i;

endmodule
